@@ rtl/ialu_pkg.sv @@
package ialu_pkg;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_DIV  = 3'd2,
		OP_MUL  = 3'd3,
		OP_POW  = 3'd4,
		OP_SQRT = 3'd5,
		OP_MOD  = 3'd6,
		OP_NONE = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DIVZERO  = 3'd1,
		ST_NEGSQRT  = 3'd2,
		ST_NEGEXP   = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// pipeline depth of every unit, set by one quotient bit per stage
	localparam int DIV_STEPS  = 32;
	localparam int LAT        = DIV_STEPS;
	localparam int SQRT_STEPS = 16;
	// exponent bits worth working on; a larger exponent saturates unless the base is 0, 1 or -1
	localparam int EXP_BITS   = 6;
	localparam int POW_STAGES = 1 + 2 * EXP_BITS;

	localparam logic [63:0] RES_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] RES_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [63:0] result;
		status_t            status;
	} rsp_t;

	typedef struct packed {
		logic [31:0] q;
		logic [31:0] r;
		logic        qneg;
		logic        rneg;
	} div_res_t;

	typedef struct packed {
		logic [63:0] mag;
		logic        sat;
		logic        neg;
	} pow_res_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage

@@ rtl/ialu_div.sv @@
module ialu_div import ialu_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output div_res_t           res
);

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] qd;
		logic [31:0] d;
		logic        qneg;
		logic        rneg;
	} div_st_t;

	// one restoring step: dividend bits leave qd at the top, quotient bits enter below
	function automatic div_st_t step(input div_st_t s);
		logic [32:0] t;
		div_st_t     o;
		o = s;
		t = {s.rem, s.qd[31]};
		if (t >= {1'b0, s.d}) begin
			o.rem = 32'(t - {1'b0, s.d});
			o.qd  = {s.qd[30:0], 1'b1};
		end else begin
			o.rem = t[31:0];
			o.qd  = {s.qd[30:0], 1'b0};
		end
		return o;
	endfunction

	div_st_t init;
	div_st_t nxt [LAT];
	div_st_t pipe_s [LAT];

	always_comb begin
		init.rem  = '0;
		init.qd   = abs32(operand_a);
		init.d    = abs32(operand_b);
		init.qneg = operand_a[31] ^ operand_b[31];
		init.rneg = operand_a[31];
	end

	for (genvar k = 0; k < LAT; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign nxt[k] = step(init);
		end else if (k < DIV_STEPS) begin : g_step
			assign nxt[k] = step(pipe_s[k-1]);
		end else begin : g_pass
			assign nxt[k] = pipe_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s <= nxt;
		end
	end

	assign res.q    = pipe_s[LAT-1].qd;
	assign res.r    = pipe_s[LAT-1].rem;
	assign res.qneg = pipe_s[LAT-1].qneg;
	assign res.rneg = pipe_s[LAT-1].rneg;

endmodule

@@ rtl/ialu_sqrt.sv @@
module ialu_sqrt import ialu_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] operand_a,
	output logic [31:0]        root
);

	typedef struct packed {
		logic [31:0] n;
		logic [31:0] root;
	} sq_st_t;

	// one digit of the bitwise root, the trial bit walks down two places a step
	function automatic sq_st_t step(input sq_st_t s, input int k);
		logic [31:0] bitv;
		logic [31:0] trial;
		sq_st_t      o;
		bitv  = 32'h4000_0000 >> (2 * k);
		trial = s.root + bitv;
		o     = s;
		if (s.n >= trial) begin
			o.n    = s.n - trial;
			o.root = (s.root >> 1) + bitv;
		end else begin
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	sq_st_t init;
	sq_st_t nxt [LAT];
	sq_st_t pipe_s [LAT];

	always_comb begin
		init.n    = operand_a[31] ? '0 : 32'(operand_a);
		init.root = '0;
	end

	for (genvar k = 0; k < LAT; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign nxt[k] = step(init, k);
		end else if (k < SQRT_STEPS) begin : g_step
			assign nxt[k] = step(pipe_s[k-1], k);
		end else begin : g_pass
			assign nxt[k] = pipe_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s <= nxt;
		end
	end

	assign root = pipe_s[LAT-1].root;

endmodule

@@ rtl/ialu_pow.sv @@
module ialu_pow import ialu_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output pow_res_t           res
);

	typedef struct packed {
		logic [63:0] p0;
		logic [63:0] p1;
		logic        zero;
		logic        sat;
	} mp_t;

	typedef struct packed {
		logic [63:0] v;
		logic        s;
	} vs_t;

	// sat means the true magnitude is above 2^63, value bits are then meaningless
	typedef struct packed {
		logic [63:0]         mag;
		logic                mag_sat;
		logic [63:0]         base;
		logic                base_sat;
		logic [EXP_BITS-1:0] e;
		logic                neg;
		mp_t                 pm;
		mp_t                 pb;
	} pw_st_t;

	// partial products of a saturating multiply; one side must fit in 32 bits
	function automatic mp_t mul_a(input logic [63:0] x, input logic xs,
	                              input logic [63:0] y, input logic ys);
		logic [31:0] sm;
		logic [63:0] lg;
		mp_t         o;
		o.zero = (!xs && x == '0) || (!ys && y == '0);
		o.sat  = !o.zero && (xs || ys || (x[63:32] != '0 && y[63:32] != '0));
		if (x[63:32] == '0) begin
			sm = x[31:0];
			lg = y;
		end else begin
			sm = y[31:0];
			lg = x;
		end
		o.p0 = sm * lg[31:0];
		o.p1 = sm * lg[63:32];
		return o;
	endfunction

	function automatic vs_t mul_b(input mp_t m);
		logic [95:0] sum;
		vs_t         o;
		sum = {32'b0, m.p0} + {m.p1, 32'b0};
		if (m.zero) begin
			o.v = '0;
			o.s = 1'b0;
		end else if (m.sat) begin
			o.v = '0;
			o.s = 1'b1;
		end else begin
			o.v = sum[63:0];
			o.s = (sum[95:63] != '0) && !(sum[95:63] == 33'd1 && sum[62:0] == '0);
		end
		return o;
	endfunction

	// one square-and-multiply round, partial products only
	function automatic pw_st_t mul_stage(input pw_st_t s, input int r);
		pw_st_t o;
		o    = s;
		o.pm = mul_a(s.mag, s.mag_sat, s.e[r] ? s.base : 64'd1, s.e[r] & s.base_sat);
		o.pb = mul_a(s.base, s.base_sat, s.base, s.base_sat);
		return o;
	endfunction

	function automatic pw_st_t comb_stage(input pw_st_t s);
		vs_t    m;
		vs_t    b;
		pw_st_t o;
		m          = mul_b(s.pm);
		b          = mul_b(s.pb);
		o          = s;
		o.mag      = m.v;
		o.mag_sat  = m.s;
		o.base     = b.v;
		o.base_sat = b.s;
		return o;
	endfunction

	pw_st_t      init;
	pw_st_t      nxt [LAT];
	pw_st_t      pipe_s [LAT];
	logic [31:0] abs_a;
	logic        big_exp;

	// exponents of 64 or more: bases 0 and 1 are settled by the low bits forced high
	always_comb begin
		abs_a         = abs32(operand_a);
		big_exp       = operand_b[30:EXP_BITS] != '0;
		init.mag      = 64'd1;
		init.mag_sat  = big_exp && abs_a > 32'd1;
		init.base     = {32'b0, abs_a};
		init.base_sat = 1'b0;
		init.e        = big_exp ? '1 : operand_b[EXP_BITS-1:0];
		init.neg      = operand_a[31] & operand_b[0];
		init.pm       = '0;
		init.pb       = '0;
	end

	for (genvar k = 0; k < LAT; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign nxt[k] = init;
		end else if (k < POW_STAGES && (k % 2) == 1) begin : g_mul
			assign nxt[k] = mul_stage(pipe_s[k-1], (k - 1) / 2);
		end else if (k < POW_STAGES) begin : g_add
			assign nxt[k] = comb_stage(pipe_s[k-1]);
		end else begin : g_pass
			assign nxt[k] = pipe_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s <= nxt;
		end
	end

	assign res.mag = pipe_s[LAT-1].mag;
	assign res.sat = pipe_s[LAT-1].mag_sat;
	assign res.neg = pipe_s[LAT-1].neg;

endmodule

@@ rtl/integer_calculator_alu.sv @@
// channel | handshake            | payload
// req     | req_valid, req_ready | req   (opcode, operand_a, operand_b)
// rsp     | rsp_valid, rsp_ready | rsp   (result, status)
//
// one request enters per cycle while the output register is empty or taken; each response
// passes through 32 stages set by the divider, one quotient bit per stage, plus the output register
// the whole pipeline advances together whenever the output register is empty or taken
// a stall on rsp freezes every stage, so nothing is dropped or repeated
// arst_n clears the valid bits only, payload registers are left alone
module integer_calculator_alu import ialu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// control line that runs alongside the arithmetic units
	typedef struct packed {
		opcode_t     op;
		status_t     st;
		logic [63:0] simple;
	} ln_t;

	logic     en;
	ln_t      ln_in;
	ln_t      line_s [LAT];
	logic     valid_s [LAT];
	ln_t      last;
	div_res_t div_r;
	logic [31:0] sq_root;
	pow_res_t pw_r;
	logic [63:0] mag;
	logic     neg;
	status_t  st;
	rsp_t     rsp_d;
	rsp_t     rsp_q;
	logic     rsp_valid_q;
	logic signed [63:0] prod;

	// pipeline moves when the output slot is free or being emptied
	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;

	// add, sub and mul finish in the first stage and ride the line
	assign prod = req.operand_a * req.operand_b;

	always_comb begin
		ln_in.op     = req.opcode;
		ln_in.st     = ST_OK;
		ln_in.simple = '0;
		unique case (req.opcode)
			OP_ADD: begin
				ln_in.simple = 64'(req.operand_a) + 64'(req.operand_b);
			end
			OP_SUB: begin
				ln_in.simple = 64'(req.operand_a) - 64'(req.operand_b);
			end
			OP_MUL: begin
				ln_in.simple = prod;
			end
			OP_DIV, OP_MOD: begin
				if (req.operand_b == '0) begin
					ln_in.st = ST_DIVZERO;
				end
			end
			OP_SQRT: begin
				if (req.operand_a[31]) begin
					ln_in.st = ST_NEGSQRT;
				end
			end
			OP_POW: begin
				if (req.operand_b[31]) begin
					ln_in.st = ST_NEGEXP;
				end
			end
			OP_NONE: begin
			end
		endcase
	end

	// valid bits travel with the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				valid_s[k] <= 1'b0;
			end
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			valid_s[0] <= req_valid;
			for (int k = 1; k < LAT; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
			rsp_valid_q <= valid_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= ln_in;
			for (int k = 1; k < LAT; k++) begin
				line_s[k] <= line_s[k-1];
			end
			rsp_q <= rsp_d;
		end
	end

	ialu_div u_div (
		.clk       (clk),
		.en        (en),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.res       (div_r)
	);

	ialu_sqrt u_sqrt (
		.clk       (clk),
		.en        (en),
		.operand_a (req.operand_a),
		.root      (sq_root)
	);

	ialu_pow u_pow (
		.clk       (clk),
		.en        (en),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.res       (pw_r)
	);

	assign last = line_s[LAT-1];

	// pick a magnitude and sign, one shared negate at the end
	always_comb begin
		mag = '0;
		neg = 1'b0;
		st  = last.st;
		if (last.st == ST_OK) begin
			unique case (last.op)
				OP_ADD, OP_SUB, OP_MUL: begin
					mag = last.simple;
				end
				OP_DIV: begin
					mag = {32'b0, div_r.q};
					neg = div_r.qneg;
				end
				OP_MOD: begin
					mag = {32'b0, div_r.r};
					neg = div_r.rneg;
				end
				OP_SQRT: begin
					mag = {32'b0, sq_root};
				end
				OP_POW: begin
					if (pw_r.neg) begin
						if (pw_r.sat) begin
							mag = RES_MIN;
							st  = ST_OVERFLOW;
						end else begin
							mag = pw_r.mag;
							neg = 1'b1;
						end
					end else if (pw_r.sat || pw_r.mag[63]) begin
						mag = RES_MAX;
						st  = ST_OVERFLOW;
					end else begin
						mag = pw_r.mag;
					end
				end
				OP_NONE: begin
				end
			endcase
		end
		rsp_d.result = neg ? -mag : mag;
		rsp_d.status = st;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/ialu_checker.sv @@
module ialu_checker import ialu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_DIVZERO || rsp.status == ST_NEGSQRT ||
		rsp.status == ST_NEGEXP) |-> rsp.result == '0)
		else $error("error response with nonzero result");

	a_ovf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OVERFLOW |->
		rsp.result == RES_MAX || rsp.result == RES_MIN)
		else $error("overflow not saturated");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("request blocked while response side is ready");

endmodule

bind integer_calculator_alu ialu_checker u_ialu_checker (.*);

@@ tb/sv/tb_integer_calculator_alu.sv @@
module tb_integer_calculator_alu;
	import ialu_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	integer_calculator_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// expected responses, oldest first
	rsp_t pending_rsp[$];
	int fail_count;
	int hold_off_cycles;
	bit rx_gaps_on;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// magnitude product, capped one above 2^63
	function automatic logic [63:0] capped_mul(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		logic [127:0] cap;
		cap = 128'h8000_0000_0000_0001;
		p = x * y;
		return (p > cap) ? cap[63:0] : p[63:0];
	endfunction

	// integer square root by bit-by-bit search
	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] r;
		r = 0;
		for (int i = 15; i >= 0; i--) begin
			if ((r | (64'd1 << i)) * (r | (64'd1 << i)) <= n) begin
				r = r | (64'd1 << i);
			end
		end
		return r;
	endfunction

	// a raised to b with saturation
	function automatic rsp_t raise_power(input logic signed [31:0] a,
			input logic signed [31:0] b);
		rsp_t o;
		logic [63:0] base;
		logic [63:0] mag;
		logic [31:0] e;
		logic neg;
		o.result = 0;
		o.status = ST_OK;
		if (b < 0) begin
			o.status = ST_NEGEXP;
			return o;
		end
		base = a[31] ? 64'(-64'(signed'(a))) : 64'(a);
		e = b;
		neg = a[31] && e[0];
		mag = 1;
		while (e != 0) begin
			if (e[0])
				mag = capped_mul(mag, base);
			e = e >> 1;
			if (e != 0)
				base = capped_mul(base, base);
		end
		if (neg) begin
			if (mag > RES_MIN) begin
				o.result = RES_MIN;
				o.status = ST_OVERFLOW;
			end else begin
				o.result = ~mag + 64'd1;
			end
		end else begin
			if (mag > RES_MAX) begin
				o.result = RES_MAX;
				o.status = ST_OVERFLOW;
			end else begin
				o.result = mag;
			end
		end
		return o;
	endfunction

	// expected response for one request
	function automatic rsp_t compute_rsp(input req_t r);
		rsp_t o;
		logic signed [63:0] a;
		logic signed [63:0] b;
		a = r.operand_a;
		b = r.operand_b;
		o.result = 0;
		o.status = ST_OK;
		case (r.opcode)
			OP_ADD: o.result = a + b;
			OP_SUB: o.result = a - b;
			OP_MUL: o.result = a * b;
			OP_DIV: begin
				if (b == 0)
					o.status = ST_DIVZERO;
				else
					o.result = a / b;
			end
			OP_MOD: begin
				if (b == 0)
					o.status = ST_DIVZERO;
				else
					o.result = a % b;
			end
			OP_POW: o = raise_power(r.operand_a, r.operand_b);
			OP_SQRT: begin
				if (a < 0)
					o.status = ST_NEGSQRT;
				else
					o.result = floor_root(a);
			end
			default: o.result = 0;
		endcase
		return o;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(5, 40);
		return $urandom_range(0, 2);
	endfunction

	// send one request, prediction recorded at acceptance
	// valid stays high so a following request can go back to back
	task automatic send_req(input opcode_t op, input logic [31:0] a, input logic [31:0] b,
			input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req_valid <= 1'b1;
		req.opcode <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		do
			@(posedge clk);
		while (!req_ready);
		pending_rsp.push_back(compute_rsp(req));
		@(negedge clk);
	endtask

	// receiver side: random stalls plus an optional long hold-off
	initial begin
		int g;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
			end
			g = rx_gaps_on ? gap_len() : 0;
			if (g > 0) begin
				rsp_ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
				@(negedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response result=%0d status=%0d", rsp.result, rsp.status);
				fail_count++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.result !== exp_rsp.result) begin
					$error("result: expected %0d actual %0d", exp_rsp.result, rsp.result);
					fail_count++;
				end
				if (rsp.status !== exp_rsp.status) begin
					$error("status: expected %0d actual %0d", exp_rsp.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	// corner values of the operands
	task automatic test_directed();
		send_req(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_req(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_req(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
		send_req(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_req(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		send_req(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		send_req(OP_DIV, 32'd7, 32'd0, 0);
		send_req(OP_MOD, 32'hFFFF_FFF9, 32'd0, 0);
		send_req(OP_DIV, 32'hFFFF_FFF9, 32'd2, 0);
		send_req(OP_MOD, 32'hFFFF_FFF9, 32'd2, 0);
		send_req(OP_SQRT, 32'h7FFF_FFFF, 32'd5, 0);
		send_req(OP_SQRT, 32'hFFFF_FFFF, 32'd0, 0);
		send_req(OP_SQRT, 32'd0, 32'd0, 0);
		send_req(OP_POW, 32'd0, 32'd0, 0);
		send_req(OP_POW, 32'd5, 32'hFFFF_FFFF, 0);
		send_req(OP_POW, 32'd0, 32'h8000_0000, 0);
		send_req(OP_POW, 32'hFFFF_FFFE, 32'd63, 0);  // exactly -2^63, no overflow
		send_req(OP_POW, 32'd2, 32'd63, 0);           // just over the positive limit
		send_req(OP_POW, 32'hFFFF_FFFD, 32'd41, 0);   // negative overflow
		send_req(OP_POW, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
		send_req(OP_POW, 32'd1, 32'h7FFF_FFFF, 0);
		send_req(OP_POW, 32'h8000_0000, 32'd2, 0);
		send_req(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 16);
			1: return -$urandom_range(0, 16);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return $urandom_range(0, 4000) - 2000;
			default: return $urandom();
		endcase
	endfunction

	// random traffic with receiver gaps, and request gaps for all but the first 50 of every 200
	task automatic test_random(input int count);
		opcode_t op;
		logic [31:0] b;
		rx_gaps_on = 1;
		for (int i = 0; i < count; i++) begin
			op = opcode_t'($urandom_range(0, 7));
			b = pick_operand();
			if (op == OP_POW && $urandom_range(0, 1))
				b = $urandom_range(0, 70);
			send_req(op, pick_operand(), b, (i % 200) >= 50);
		end
	endtask

	// receiver holds off while requests keep coming, so the pipeline backs up
	task automatic test_backpressure();
		hold_off_cycles = 120;
		rx_gaps_on = 0;
		for (int i = 0; i < 80; i++)
			send_req(opcode_t'($urandom_range(0, 7)), $urandom(), $urandom(), 0);
		rx_gaps_on = 1;
	endtask

	initial begin
		int waited;
		fail_count = 0;
		hold_off_cycles = 0;
		rx_gaps_on = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(1650);
		req_valid <= 1'b0;
		waited = 0;
		while (pending_rsp.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LAT + 10) @(posedge clk);
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ integer_calculator_alu.f @@
rtl/ialu_pkg.sv
rtl/ialu_div.sv
rtl/ialu_sqrt.sv
rtl/ialu_pow.sv
rtl/integer_calculator_alu.sv
rtl/ialu_checker.sv
tb/sv/tb_integer_calculator_alu.sv
